FILE: hdl/pns_pkg.sv
package pns_pkg;

    // Sizes of the stored sequence.
    localparam int MAX_BASES   = 16384;
    localparam int STORE_BYTES = (MAX_BASES + 3) / 4;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COUNT_W     = 15;
    localparam int POS_W       = 14;
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // ASCII characters.
    localparam logic [CHAR_W-1:0] CHAR_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C  = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G  = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T  = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_N  = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_LA = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_LG = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_LT = 8'h74;

    // Two-bit base codes.
    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_C = 2'd1;
    localparam logic [1:0] CODE_G = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic load;
        logic push;
    } pns_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic out_busy;
    } pns_stat_t;

    function automatic logic [1:0] char_code(input logic [CHAR_W-1:0] c);
        logic [1:0] code;
        case (c)
            CHAR_C, CHAR_LC: code = CODE_C;
            CHAR_G, CHAR_LG: code = CODE_G;
            CHAR_T, CHAR_LT: code = CODE_T;
            default:         code = CODE_A;
        endcase
        return code;
    endfunction

    function automatic logic [CHAR_W-1:0] fwd_base(input logic [1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            CODE_A:  ch = CHAR_A;
            CODE_C:  ch = CHAR_C;
            CODE_G:  ch = CHAR_G;
            default: ch = CHAR_T;
        endcase
        return ch;
    endfunction

    function automatic logic [CHAR_W-1:0] rev_base(input logic [1:0] code);
        logic [CHAR_W-1:0] ch;
        case (code)
            CODE_A:  ch = CHAR_T;
            CODE_C:  ch = CHAR_G;
            CODE_G:  ch = CHAR_C;
            default: ch = CHAR_A;
        endcase
        return ch;
    endfunction

endpackage

FILE: hdl/pns_if.sv
interface pns_req_if;
    import pns_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CHAR_W-1:0] base_char;
    logic [POS_W-1:0]  position;
    logic              forward;

    modport source (output valid, kind, base_char, position, forward, input ready);
    modport sink   (input valid, kind, base_char, position, forward, output ready);
endinterface

interface pns_rsp_if;
    import pns_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHAR_W-1:0]  base_out;
    logic [COUNT_W-1:0] seq_length;
    logic               status;

    modport source (output valid, base_out, seq_length, status, input ready);
    modport sink   (input valid, base_out, seq_length, status, output ready);
endinterface

FILE: hdl/pns_ctrl.sv
module pns_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  pns_pkg::pns_stat_t stat,
    output pns_pkg::pns_cmd_t  cmd
);
    import pns_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = stat.is_read ? S_LOAD : S_PUSH;
            end
            S_LOAD:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!stat.out_busy)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready   = (state_reg == S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && req_valid;
    assign cmd.exec    = (state_reg == S_EXEC);
    assign cmd.load    = (state_reg == S_LOAD);
    assign cmd.push    = (state_reg == S_PUSH) && !stat.out_busy;

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec, cmd.load, cmd.push}))
        else $error("more than one datapath command at once");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && stat.is_read) |=> cmd.load)
        else $error("read item did not go on to the memory data cycle");

endmodule

FILE: hdl/pns_dp.sv
module pns_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pns_pkg::pns_cmd_t           cmd,
    output pns_pkg::pns_stat_t          stat,
    input  logic [pns_pkg::KIND_W-1:0]  kind,
    input  logic [pns_pkg::CHAR_W-1:0]  base_char,
    input  logic [pns_pkg::POS_W-1:0]   position,
    input  logic                        forward,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pns_pkg::CHAR_W-1:0]  base_out,
    output logic [pns_pkg::COUNT_W-1:0] seq_length,
    output logic                        status
);
    import pns_pkg::*;

    // Captured item.
    logic [KIND_W-1:0]  kind_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               fwd_reg;

    // Sequence state.
    logic [COUNT_W-1:0] count_reg;
    logic [7:0]         tail_reg;

    // Read bookkeeping and result.
    logic               miss_reg;
    logic [1:0]         slot_rd_reg;
    logic [7:0]         rd_data_reg;
    logic [CHAR_W-1:0]  res_base_reg;
    logic               res_status_reg;

    // Output register.
    logic               out_valid_reg;
    logic [CHAR_W-1:0]  out_base_reg;
    logic [COUNT_W-1:0] out_len_reg;
    logic               out_status_reg;

    logic [7:0]         mem [STORE_BYTES];

    logic               full;
    logic [1:0]         code;
    logic [1:0]         slot_wr;
    logic [7:0]         tail_next;
    logic [ADDR_W-1:0]  wr_addr;
    logic               mem_we;
    logic [COUNT_W-1:0] pos_ext;
    logic               miss;
    logic [COUNT_W-1:0] eff_pos;
    logic [ADDR_W-1:0]  rd_addr;
    logic [1:0]         rd_code;

    assign full    = (count_reg >= COUNT_W'(MAX_BASES));
    assign code    = char_code(char_reg);
    assign slot_wr = count_reg[1:0];
    assign wr_addr = count_reg[ADDR_W+1:2];

    // The tail register mirrors the byte being filled, so an append needs no read.
    assign tail_next = (slot_wr == 2'd0) ? {6'd0, code}
                                         : (tail_reg | ({6'd0, code} << {slot_wr, 1'b0}));
    assign mem_we    = cmd.exec && (kind_reg == KIND_APPEND) && !full;

    assign pos_ext = {1'b0, pos_reg};
    assign miss    = (pos_ext >= count_reg);
    assign eff_pos = fwd_reg ? pos_ext : (count_reg - COUNT_W'(1) - pos_ext);
    assign rd_addr = eff_pos[ADDR_W+1:2];
    assign rd_code = 2'(rd_data_reg >> {slot_rd_reg, 1'b0});

    assign stat.is_read  = (kind_reg == KIND_READ);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= tail_next;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            char_reg <= base_char;
            pos_reg  <= position;
            fwd_reg  <= forward;
        end
        if (mem_we)
        begin
            tail_reg <= tail_next;
        end
        if (cmd.exec)
        begin
            miss_reg    <= miss;
            slot_rd_reg <= eff_pos[1:0];
            case (kind_reg)
                KIND_APPEND:
                begin
                    res_base_reg   <= fwd_base(code);
                    res_status_reg <= full;
                end
                default:
                begin
                    res_base_reg   <= '0;
                    res_status_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.load)
        begin
            res_base_reg <= miss_reg ? CHAR_N
                          : (fwd_reg ? fwd_base(rd_code) : rev_base(rd_code));
        end
        if (cmd.push)
        begin
            out_base_reg   <= res_base_reg;
            out_len_reg    <= count_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
            else if (cmd.exec && (kind_reg == KIND_CLEAR))
            begin
                count_reg <= '0;
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign base_out   = out_base_reg;
    assign seq_length = out_len_reg;
    assign status     = out_status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_BASES))
        else $error("base count beyond capacity");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (count_reg == $past(count_reg) + COUNT_W'(1)))
        else $error("stored append did not advance the base count");

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an untaken beat");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.push))
        else $error("result beat raised without a push");

endmodule

FILE: hdl/packed_nucleotide_store_core.sv
// Packed nucleotide store: keeps a DNA sequence of up to 16384 bases, packed
// four bases per byte with the first base of each byte in the low two bits.
// The request channel carries one item per beat: kind 0 appends base_char,
// kind 1 reads the base at position (forward or reverse complement strand),
// kind 2 clears the sequence; kind 3 changes nothing.
// The response channel returns exactly one beat per request: the base as
// ASCII ('N' for a position at or beyond the length), the length after the
// item, and status 1 when an append was dropped because the store is full.
// The block works on one item at a time. An append, clear or unused kind
// goes through the execute and push states to its response beat; a read
// has a memory data state between them, the registered read of the byte
// memory. Request ready returns at the edge that loads the response
// register, so a new item is taken only once the last result is pushed.
// The response sits in an output register; if the receiver stalls, the
// finished result is held there and the next result waits in the datapath
// until that beat is taken. Reset empties the sequence and drops any beat in
// flight; the byte memory is not cleared, as only written bytes are read.
module packed_nucleotide_store_core (
    input logic       clk,
    input logic       rst_n,
    pns_req_if.sink   request,
    pns_rsp_if.source response
);
    import pns_pkg::*;

    pns_cmd_t  cmd;
    pns_stat_t stat;

    // Controller: sequences capture, execute, memory data and result push.
    pns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: item registers, base count, byte memory and output register.
    pns_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .kind       (request.kind),
        .base_char  (request.base_char),
        .position   (request.position),
        .forward    (request.forward),
        .out_valid  (response.valid),
        .out_ready  (response.ready),
        .base_out   (response.base_out),
        .seq_length (response.seq_length),
        .status     (response.status)
    );

endmodule

FILE: verif/pns_store_check.sv
`timescale 1ns / 100ps

module pns_store_check (
    input  logic clk,
    input  logic rst_n,
    pns_req_if   request,
    pns_rsp_if   response,
    output int   mismatches,
    output int   outstanding
);
    import pns_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0]  base;
        logic [COUNT_W-1:0] length;
        logic               status;
    } store_reply_t;

    // Shadow of the packed byte memory and of the sequence length.
    logic [7:0]         shadow_bytes [STORE_BYTES];
    logic [COUNT_W-1:0] shadow_count = '0;
    store_reply_t       due_responses [$];
    int                 fail_tally = 0;
    int                 due_tally = 0;

    assign mismatches  = fail_tally;
    assign outstanding = due_tally;

    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [1:0] code;
        case (ch)
            CHAR_C, CHAR_LC: code = CODE_C;
            CHAR_G, CHAR_LG: code = CODE_G;
            CHAR_T, CHAR_LT: code = CODE_T;
            default:         code = CODE_A;
        endcase
        return code;
    endfunction

    // The complement of a two-bit code is its bitwise inverse (A-T, C-G).
    function automatic logic [CHAR_W-1:0] code_letter(input logic [1:0] code,
                                                      input logic complement);
        logic [1:0]        strand_code;
        logic [CHAR_W-1:0] letter;
        strand_code = complement ? ~code : code;
        case (strand_code)
            CODE_A:  letter = CHAR_A;
            CODE_C:  letter = CHAR_C;
            CODE_G:  letter = CHAR_G;
            default: letter = CHAR_T;
        endcase
        return letter;
    endfunction

    function automatic store_reply_t apply_store_item(input logic [KIND_W-1:0] kind,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [POS_W-1:0]  pos,
                                                      input logic              fwd);
        store_reply_t       reply;
        logic [1:0]         code;
        logic [1:0]         slot;
        logic [COUNT_W-1:0] idx;
        logic [ADDR_W-1:0]  byte_sel;
        reply = '0;
        case (kind)
            KIND_APPEND:
            begin
                code       = base_code(ch);
                reply.base = code_letter(code, 1'b0);
                if (shadow_count >= MAX_BASES)
                begin
                    reply.status = 1'b1;
                end
                else
                begin
                    byte_sel = shadow_count[2 +: ADDR_W];
                    slot     = shadow_count[1:0];
                    if (slot == 2'd0)
                    begin
                        shadow_bytes[byte_sel] = 8'h00;
                    end
                    shadow_bytes[byte_sel][slot*2 +: 2] = code;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            KIND_READ:
            begin
                if (COUNT_W'(pos) >= shadow_count)
                begin
                    reply.base = CHAR_N;
                end
                else
                begin
                    idx = fwd ? COUNT_W'(pos) : shadow_count - 1'b1 - COUNT_W'(pos);
                    code = shadow_bytes[idx[2 +: ADDR_W]][idx[1:0]*2 +: 2];
                    reply.base = code_letter(code, !fwd);
                end
            end
            KIND_CLEAR:
            begin
                shadow_count = '0;
            end
            default:
            begin
            end
        endcase
        reply.length = shadow_count;
        return reply;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (fail_tally < 40)
        begin
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        end
        fail_tally++;
    endtask

    always @(posedge clk)
    begin : watch_beats
        store_reply_t want;
        store_reply_t fresh;
        if (rst_n)
        begin
            if (request.valid && request.ready)
            begin
                fresh = apply_store_item(request.kind, request.base_char,
                                         request.position, request.forward);
                due_responses = {due_responses, fresh};
            end
            if (response.valid && response.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    report_mismatch("response beat with nothing awaited",
                                    response.base_out, 0);
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (response.base_out !== want.base)
                    begin
                        report_mismatch("base_out", response.base_out, want.base);
                    end
                    if (response.seq_length !== want.length)
                    begin
                        report_mismatch("seq_length", response.seq_length, want.length);
                    end
                    if (response.status !== want.status)
                    begin
                        report_mismatch("status", response.status, want.status);
                    end
                end
            end
            due_tally = due_responses.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import pns_pkg::*;

    // Kind 3 is not defined by the block; it must leave the store untouched.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Number of random items after the directed part.
    localparam int RANDOM_ITEMS = 1700;

    // Cycles without a single beat on either channel before the run is
    // declared hung. Both sides idle at random, but a gap of this size can
    // only mean the block has stalled.
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    pns_req_if request ();
    pns_rsp_if response ();

    // When clear, neither side inserts random gaps.
    bit idling = 1'b1;

    int mismatches;
    int outstanding;
    int quiet_cycles = 0;

    // Length of the sequence as the stimulus sees it, used only to aim read
    // positions at stored bases.
    int stored_bases = 0;

    // Characters that map to a real base; the rest of the byte range is
    // sent too and must fold to A.
    logic [CHAR_W-1:0] base_letters [8] = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T,
                                            CHAR_LA, CHAR_LC, CHAR_LG, CHAR_LT};

    always #1 clk = ~clk;

    packed_nucleotide_store_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response)
    );

    pns_store_check u_store_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (request),
        .response    (response),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // The receiver stalls at random while idling is enabled, and takes
    // every beat as soon as it is offered otherwise.
    initial
    begin
        response.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            response.ready <= !idling || ($urandom_range(0, 99) >= 37);
        end
    end

    // Any beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((request.valid && request.ready) || (response.valid && response.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request beat and returns at the falling edge after it has
    // been taken. Fields are set at the falling edge and the handshake is
    // judged at the rising edge, so the block always sees settled inputs.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                             input logic [POS_W-1:0] pos, input logic fwd);
        while (idling && $urandom_range(0, 99) < 37)
        begin
            request.valid <= 1'b0;
            @(negedge clk);
        end
        request.valid     <= 1'b1;
        request.kind      <= kind;
        request.base_char <= ch;
        request.position  <= pos;
        request.forward   <= fwd;
        @(posedge clk);
        while (!request.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (kind == KIND_APPEND && stored_bases < MAX_BASES)
        begin
            stored_bases++;
        end
        else if (kind == KIND_CLEAR)
        begin
            stored_bases = 0;
        end
    endtask

    // Holds the request side quiet until every awaited response beat has
    // arrived. The loop waits for a falling edge before its first test, so
    // valid is never lowered and raised again within one time step.
    task automatic drain_responses();
        request.valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
    endtask

    function automatic logic [CHAR_W-1:0] random_char();
        if ($urandom_range(0, 99) < 60)
        begin
            return base_letters[$urandom_range(0, 7)];
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Reads mostly land on stored bases, the rest anywhere in the index range.
    function automatic logic [POS_W-1:0] read_position();
        if (stored_bases > 0 && $urandom_range(0, 99) < 80)
        begin
            return POS_W'($urandom_range(0, stored_bases - 1));
        end
        return POS_W'($urandom_range(0, (1 << POS_W) - 1));
    endfunction

    // One random item: mostly appends and reads, now and then a clear, so
    // that the sequence keeps growing and shrinking, plus a little of the
    // unused kind.
    task automatic send_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            send_item(KIND_APPEND, random_char(), POS_W'($urandom_range(0, 16383)),
                      1'($urandom_range(0, 1)));
        end
        else if (pick < 95)
        begin
            send_item(KIND_READ, CHAR_W'($urandom_range(0, 255)), read_position(),
                      1'($urandom_range(0, 1)));
        end
        else if (pick < 97)
        begin
            send_item(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                      POS_W'($urandom_range(0, 16383)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            send_item(KIND_UNUSED, random_char(), POS_W'($urandom_range(0, 16383)),
                      1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        request.valid     = 1'b0;
        request.kind      = KIND_APPEND;
        request.base_char = '0;
        request.position  = '0;
        request.forward   = 1'b0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The sequence is empty straight after reset, so a read gives N.
        send_item(KIND_READ, '0, '0, 1'b1);

        // Every letter in both cases, then characters that are not bases.
        for (int i = 0; i < 8; i++)
        begin
            send_item(KIND_APPEND, base_letters[i], '0, 1'b0);
        end
        send_item(KIND_APPEND, 8'h00, '0, 1'b0);
        send_item(KIND_APPEND, CHAR_N, '0, 1'b1);

        // Ten bases stored: last base, first base on the reverse strand, the
        // first index past the end, and the top of the index range.
        send_item(KIND_READ, '0, POS_W'(9), 1'b1);
        send_item(KIND_READ, '0, POS_W'(0), 1'b0);
        send_item(KIND_READ, '0, POS_W'(10), 1'b1);
        send_item(KIND_READ, '0, '1, 1'b0);
        send_item(KIND_UNUSED, CHAR_C, POS_W'(5), 1'b1);

        // A run of appends with no gaps on either side.
        idling = 1'b0;
        for (int i = 0; i < 60; i++)
        begin
            send_item(KIND_APPEND, random_char(), POS_W'($urandom_range(0, 16383)),
                      1'($urandom_range(0, 1)));
        end
        idling = 1'b1;

        // Both ends of both strands of the longer sequence.
        send_item(KIND_READ, '0, '0, 1'b1);
        send_item(KIND_READ, '0, POS_W'(69), 1'b1);
        send_item(KIND_READ, '0, '0, 1'b0);
        send_item(KIND_READ, '0, POS_W'(69), 1'b0);

        // Wait for the whole pipeline to empty before the store is cleared.
        drain_responses();

        // Clear, then a read of the empty sequence, which must give N.
        send_item(KIND_CLEAR, CHAR_A, '0, 1'b1);
        send_item(KIND_READ, '0, '0, 1'b1);

        // Random traffic. One stretch runs with no gaps, and the sender
        // stops now and then until every response beat has come back.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            idling = !(i >= 600 && i < 900);
            if (i % 450 == 449)
            begin
                drain_responses();
            end
            send_random_item();
        end
        idling = 1'b1;

        drain_responses();
        repeat (10) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pns_pkg.sv
hdl/pns_if.sv
hdl/pns_ctrl.sv
hdl/pns_dp.sv
hdl/packed_nucleotide_store_core.sv
verif/pns_store_check.sv
verif/tb.sv
